// ----- src/morse_key_timing_decoder_top_macros.svh -----
// Assertion macros used by the Morse key timing decoder checker.
`ifndef MORSE_KEY_TIMING_DECODER_TOP_MACROS_SVH
`define MORSE_KEY_TIMING_DECODER_TOP_MACROS_SVH

// Check a consequence in the same cycle as its trigger.
`define MKTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its trigger.
`define MKTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/mktd_pkg.sv -----
// Shared types, constants and the Morse code table of the key timing decoder.
package mktd_pkg;

    // Field widths
    localparam int DUR_W  = 16;
    localparam int CHAR_W = 7;
    localparam int DOT_W  = 12;
    localparam int THR_W  = DOT_W + 6;

    // Parameter defaults
    localparam int MAX_CODE_LEN_DEF  = 7;
    localparam int DURATION_BITS_DEF = 16;

    // Register reset value
    localparam logic [DOT_W-1:0] DOT_UNIT_RESET = 12'd200;

    // Operation codes
    localparam logic OP_MARK = 1'b0;
    localparam logic OP_GAP  = 1'b1;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'd0;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'd32;
    localparam logic [CHAR_W-1:0] CHAR_ILLEGAL = 7'd35;

    // Code table geometry: index is a leading one followed by the symbols
    localparam int ROM_IW      = 8;
    localparam int ROM_DEPTH   = 1 << ROM_IW;
    localparam int ROM_MAX_LEN = ROM_IW - 1;
    localparam logic [7:0] ROM_EMPTY  = 8'h00;
    localparam logic [7:0] ROM_PREFIX = 8'h80;

    // Result queue depth (power of two)
    localparam int RES_FIFO_DEPTH = 4;

    typedef logic [7:0] rom_t [ROM_DEPTH];

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              has_char;
        logic              message_end;
    } res_t;

    typedef struct packed {
        logic [1:0] num;
        res_t       first;
        res_t       second;
    } res_bundle_t;

    // Table seeds: {index, ASCII}, dash = 1, first symbol highest
    localparam int NUM_SEEDS = 53;
    localparam logic [ROM_IW+CHAR_W-1:0] SEEDS [NUM_SEEDS] = '{
        {8'd5,   7'd65}, {8'd24,  7'd66}, {8'd26,  7'd67}, {8'd12,  7'd68},
        {8'd2,   7'd69}, {8'd18,  7'd70}, {8'd14,  7'd71}, {8'd16,  7'd72},
        {8'd4,   7'd73}, {8'd23,  7'd74}, {8'd13,  7'd75}, {8'd20,  7'd76},
        {8'd7,   7'd77}, {8'd6,   7'd78}, {8'd15,  7'd79}, {8'd22,  7'd80},
        {8'd29,  7'd81}, {8'd10,  7'd82}, {8'd8,   7'd83}, {8'd3,   7'd84},
        {8'd9,   7'd85}, {8'd17,  7'd86}, {8'd11,  7'd87}, {8'd25,  7'd88},
        {8'd27,  7'd89}, {8'd28,  7'd90}, {8'd63,  7'd48}, {8'd47,  7'd49},
        {8'd39,  7'd50}, {8'd35,  7'd51}, {8'd33,  7'd52}, {8'd32,  7'd53},
        {8'd48,  7'd54}, {8'd56,  7'd55}, {8'd60,  7'd56}, {8'd62,  7'd57},
        {8'd76,  7'd63}, {8'd107, 7'd33}, {8'd85,  7'd46}, {8'd115, 7'd44},
        {8'd120, 7'd58}, {8'd97,  7'd45}, {8'd50,  7'd47}, {8'd49,  7'd61},
        {8'd94,  7'd39}, {8'd54,  7'd40}, {8'd109, 7'd41}, {8'd82,  7'd34},
        {8'd90,  7'd64}, {8'd137, 7'd36}, {8'd40,  7'd38}, {8'd106, 7'd59},
        {8'd77,  7'd95}
    };

    // Build the table: characters at their codes, prefix marks on the path
    function automatic rom_t build_rom();
        rom_t              rom;
        logic [ROM_IW-1:0] idx;
        logic [ROM_IW-1:0] anc;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = ROM_EMPTY;
        end
        for (int s = 0; s < NUM_SEEDS; s++) begin
            idx = SEEDS[s][ROM_IW+CHAR_W-1:CHAR_W];
            for (int k = 1; k < ROM_IW; k++) begin
                anc = idx >> k;
                if (anc > ROM_IW'(1)) begin
                    rom[anc] = ROM_PREFIX;
                end
            end
        end
        for (int s = 0; s < NUM_SEEDS; s++) begin
            rom[SEEDS[s][ROM_IW+CHAR_W-1:CHAR_W]] = {1'b0, SEEDS[s][CHAR_W-1:0]};
        end
        return rom;
    endfunction

    localparam rom_t CODE_ROM = build_rom();

endpackage

// ----- src/mktd_if.sv -----
// Channel interfaces of the key timing decoder: key events, text results, setup.

interface mktd_item_if;
    import mktd_pkg::*;
    logic             valid;
    logic             ready;
    logic             operation;
    logic [DUR_W-1:0] duration_ms;

    modport source (output valid, output operation, output duration_ms, input ready);
    modport sink   (input valid, input operation, input duration_ms, output ready);
endinterface

interface mktd_result_if;
    import mktd_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              has_char;
    logic              message_end;

    modport source (output valid, output character, output has_char, output message_end,
                     input ready);
    modport sink   (input valid, input character, input has_char, input message_end,
                     output ready);
endinterface

interface mktd_cfg_if;
    import mktd_pkg::*;
    logic             valid;
    logic             ready;
    logic [DOT_W-1:0] dot_unit_ms;

    modport source (output valid, output dot_unit_ms, input ready);
    modport sink   (input valid, input dot_unit_ms, output ready);
endinterface

// ----- src/mktd_core.sv -----
// Letter state and single-pass event classification with code table lookup.
module mktd_core #(
    parameter int MAX_CODE_LEN  = mktd_pkg::MAX_CODE_LEN_DEF,
    parameter int DURATION_BITS = mktd_pkg::DURATION_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic                         operation,
    input  logic [mktd_pkg::DUR_W-1:0]   duration_ms,
    input  logic [mktd_pkg::DOT_W-1:0]   dot_unit_ms,
    output mktd_pkg::res_bundle_t        res
);
    import mktd_pkg::*;

    localparam int CW = $clog2(MAX_CODE_LEN + 2);
    localparam logic [DUR_W-1:0] DMAX = (DURATION_BITS >= DUR_W) ? {DUR_W{1'b1}}
                                        : DUR_W'((1 << DURATION_BITS) - 1);

    logic [MAX_CODE_LEN-1:0] pattern_reg, pattern_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    in_msg_reg, in_msg_next;

    logic [DOT_W-1:0]  unit;
    logic [THR_W-1:0]  t_ext, t2, t5, t7, t21;
    logic [DUR_W-1:0]  dur_sat;
    logic [THR_W-1:0]  d_ext, d2;
    logic [ROM_IW-1:0] rom_idx;
    logic [ROM_IW-1:0] rom_mask;
    logic [7:0]        rom_entry;
    logic [CHAR_W-1:0] letter_char;
    logic              letter_has;
    logic              symbol_bit;
    res_t              letter_res;

    // Thresholds from the dot unit, zero treated as one
    always_comb
    begin
        unit  = (dot_unit_ms == '0) ? DOT_W'(1) : dot_unit_ms;
        t_ext = THR_W'(unit);
        t2    = t_ext << 1;
        t5    = (t_ext << 2) + t_ext;
        t7    = (t_ext << 3) - t_ext;
        t21   = (t_ext << 4) + (t_ext << 2) + t_ext;
        dur_sat = (duration_ms > DMAX) ? DMAX : duration_ms;
        d_ext = THR_W'(dur_sat);
        d2    = d_ext << 1;
    end

    // Look up the pending letter
    always_comb
    begin
        rom_mask  = (ROM_IW'(1) << count_reg) - ROM_IW'(1);
        rom_idx   = (ROM_IW'(1) << count_reg) | (ROM_IW'(pattern_reg) & rom_mask);
        rom_entry = CODE_ROM[rom_idx];
        letter_has  = 1'b0;
        letter_char = CHAR_NONE;
        if (count_reg == '0) begin
            letter_has = 1'b0;
        end else if (count_reg > CW'(MAX_CODE_LEN) || count_reg > CW'(ROM_MAX_LEN)) begin
            letter_has  = 1'b1;
            letter_char = CHAR_ILLEGAL;
        end else if (rom_entry == ROM_EMPTY) begin
            letter_has  = 1'b1;
            letter_char = CHAR_ILLEGAL;
        end else if (rom_entry != ROM_PREFIX) begin
            letter_has  = 1'b1;
            letter_char = rom_entry[CHAR_W-1:0];
        end
        letter_res.character   = letter_char;
        letter_res.has_char    = letter_has;
        letter_res.message_end = 1'b0;
    end

    // Classify the event, advance the letter, emit up to two results
    always_comb
    begin
        pattern_next = pattern_reg;
        count_next   = count_reg;
        in_msg_next  = in_msg_reg;
        symbol_bit   = 1'b0;
        res          = '0;
        if (fire) begin
            case (operation)
                OP_MARK:
                begin
                    if (d_ext < t5) begin
                        symbol_bit  = (d_ext >= t2);
                        in_msg_next = 1'b1;
                        if (count_reg < CW'(MAX_CODE_LEN + 1)) begin
                            pattern_next = {pattern_reg[MAX_CODE_LEN-2:0], symbol_bit};
                            count_next   = count_reg + CW'(1);
                        end
                    end else begin
                        pattern_next = '0;
                        count_next   = '0;
                        in_msg_next  = 1'b0;
                        res.num      = 2'd1;
                        res.first    = letter_res;
                        res.first.message_end = 1'b1;
                    end
                end
                OP_GAP:
                begin
                    if (in_msg_reg && d2 >= t5) begin
                        pattern_next = '0;
                        count_next   = '0;
                        if (d_ext < t7) begin
                            res.num   = letter_has ? 2'd1 : 2'd0;
                            res.first = letter_res;
                        end else if (d_ext < t21) begin
                            if (letter_has) begin
                                res.num    = 2'd2;
                                res.first  = letter_res;
                                res.second = '{character: CHAR_SPACE, has_char: 1'b1,
                                               message_end: 1'b0};
                            end else begin
                                res.num   = 2'd1;
                                res.first = '{character: CHAR_SPACE, has_char: 1'b1,
                                              message_end: 1'b0};
                            end
                        end else begin
                            in_msg_next = 1'b0;
                            res.num     = 2'd1;
                            res.first   = letter_res;
                            res.first.message_end = 1'b1;
                        end
                    end
                end
                default:
                begin
                    res = '0;
                end
            endcase
        end
    end

    // Hold the letter and message state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pattern_reg <= '0;
            count_reg   <= '0;
            in_msg_reg  <= 1'b0;
        end else begin
            pattern_reg <= pattern_next;
            count_reg   <= count_next;
            in_msg_reg  <= in_msg_next;
        end
    end

endmodule

// ----- src/mktd_res_fifo.sv -----
// Result queue taking up to two results per cycle and giving one per cycle while popped.
module mktd_res_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mktd_pkg::res_bundle_t push,
    input  logic                  pop,
    output logic                  room,
    output logic                  not_empty,
    output mktd_pkg::res_t        head
);
    import mktd_pkg::*;

    localparam int PW  = $clog2(RES_FIFO_DEPTH);
    localparam int CNW = $clog2(RES_FIFO_DEPTH + 1);

    res_t           mem_reg [RES_FIFO_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0] count_reg, count_next;
    logic           pop_ok;

    assign not_empty = (count_reg != '0);
    assign room      = (count_reg <= CNW'(RES_FIFO_DEPTH - 2));
    assign head      = mem_reg[rd_ptr_reg];
    assign pop_ok    = pop && not_empty;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.num);
        rd_ptr_next = rd_ptr_reg + PW'(pop_ok);
        count_next  = count_reg + CNW'(push.num) - CNW'(pop_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed results in order
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem_reg[wr_ptr_reg + PW'(1)] <= push.second;
        end
    end

endmodule

// ----- src/morse_key_timing_decoder_top.sv -----
// Morse key timing decoder: key mark/gap durations in, decoded text stream out.
// A key event is held in the input register, then decoded into the result queue.
// Throughput: one key event per cycle while the queue has room; a letter and space
// from one event take two of its four entries, drained one per cycle when ready.
// Reset clears letter state, message flag and queue, and sets the dot unit to 200.
module morse_key_timing_decoder_top #(
    parameter int MAX_CODE_LEN  = mktd_pkg::MAX_CODE_LEN_DEF,
    parameter int DURATION_BITS = mktd_pkg::DURATION_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mktd_cfg_if.sink             cfg,
    mktd_item_if.sink            item,
    mktd_result_if.source        result
);
    import mktd_pkg::*;

    logic [DOT_W-1:0] dot_reg, dot_next;
    logic             s1_valid_reg, s1_valid_next;
    logic             s1_op_reg;
    logic [DUR_W-1:0] s1_dur_reg;
    logic             s1_fire;
    logic             fifo_room;
    logic             fifo_not_empty;
    res_t             fifo_head;
    res_bundle_t      core_res;
    logic             item_accept;

    // Setup register: always ready
    assign cfg.ready = 1'b1;
    assign dot_next  = (cfg.valid) ? cfg.dot_unit_ms : dot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            dot_reg <= DOT_UNIT_RESET;
        end else begin
            dot_reg <= dot_next;
        end
    end

    // Input register: refill as the held request moves on
    assign s1_fire     = s1_valid_reg && fifo_room;
    assign item.ready  = !s1_valid_reg || s1_fire;
    assign item_accept = item.valid && item.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept) begin
            s1_op_reg  <= item.operation;
            s1_dur_reg <= item.duration_ms;
        end
    end

    // Decode the held event
    mktd_core #(
        .MAX_CODE_LEN  (MAX_CODE_LEN),
        .DURATION_BITS (DURATION_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (s1_fire),
        .operation   (s1_op_reg),
        .duration_ms (s1_dur_reg),
        .dot_unit_ms (dot_reg),
        .res         (core_res)
    );

    // Queue results toward the output
    mktd_res_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (core_res),
        .pop       (result.ready),
        .room      (fifo_room),
        .not_empty (fifo_not_empty),
        .head      (fifo_head)
    );

    assign result.valid       = fifo_not_empty;
    assign result.character   = fifo_head.character;
    assign result.has_char    = fifo_head.has_char;
    assign result.message_end = fifo_head.message_end;

endmodule

// ----- src/mktd_checker.sv -----
// Port-level checker for the key timing decoder, bound to the top level.
`include "morse_key_timing_decoder_top_macros.svh"

module mktd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [mktd_pkg::CHAR_W-1:0] res_character,
    input logic                        res_has_char,
    input logic                        res_message_end
);
    import mktd_pkg::*;

    // A result without a character carries a zero code
    `MKTD_ASSERT_SAME(a_empty_res_zero, res_valid && !res_has_char, res_character == CHAR_NONE, "empty result with nonzero character")

    // A result without a character only closes a message
    `MKTD_ASSERT_SAME(a_empty_res_ends, res_valid && !res_has_char, res_message_end, "empty result not at message end")

    // A word space never ends a message
    `MKTD_ASSERT_SAME(a_space_not_end, res_valid && res_has_char && res_character == CHAR_SPACE, !res_message_end, "word space marked as message end")

    // A stalled result holds
    `MKTD_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_character) && $stable(res_has_char) && $stable(res_message_end), "stalled result changed")

endmodule

bind morse_key_timing_decoder_top mktd_checker u_mktd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_character   (result.character),
    .res_has_char    (result.has_char),
    .res_message_end (result.message_end)
);

// ----- bench/tb_morse_key_timing_decoder_top.sv -----
// Self-checking bench for the Morse key timing decoder: key events in, decoded text out.

// Scoreboard: tracks decoder state, predicts text for each key request, checks results
class morse_text_scoreboard;
    logic [7:0]     code_rom [256];
    logic [6:0]     pattern;
    int             sym_count;
    bit             in_message;
    logic [11:0]    dot_unit;
    mktd_pkg::res_t text_q [$];
    int             errors;
    int             checked;
    int             chars_seen;
    int             ends_seen;

    // Build the code table from "<char><code>" tokens and load reset state
    function new();
        string      table_text;
        int         idx;
        logic [7:0] ch;
        bit         at_start;
        table_text = {"A.- B-... C-.-. D-.. E. F..-. G--. H.... I.. J.--- K-.- L.-.. ",
                      "M-- N-. O--- P.--. Q--.- R.-. S... T- U..- V...- W.-- X-..- ",
                      "Y-.-- Z--.. 0----- 1.---- 2..--- 3...-- 4....- 5..... 6-.... ",
                      "7--... 8---.. 9----. ?..--.. !-.-.-- ..-.-.- ,--..-- :---... ",
                      "--....- /-..-. =-...- '.----. (-.--. )-.--.- \".-..-. @.--.-. ",
                      "$...-..- &.-... ;-.-.-. _..--.-"};
        for (int i = 0; i < 256; i++) begin
            code_rom[i] = mktd_pkg::ROM_EMPTY;
        end
        idx = 1;
        ch = 8'd0;
        at_start = 1'b1;
        for (int i = 0; i <= table_text.len(); i++) begin
            if (i == table_text.len() || table_text[i] == " ") begin
                if (!at_start) begin
                    code_rom[idx] = ch;
                end
                at_start = 1'b1;
                idx = 1;
            end else if (at_start) begin
                ch = table_text[i];
                at_start = 1'b0;
            end else begin
                idx = (idx << 1) | ((table_text[i] == "-") ? 1 : 0);
                if (code_rom[idx] == mktd_pkg::ROM_EMPTY) begin
                    code_rom[idx] = mktd_pkg::ROM_PREFIX;
                end
            end
        end
        pattern = '0;
        sym_count = 0;
        in_message = 1'b0;
        dot_unit = mktd_pkg::DOT_UNIT_RESET;
        errors = 0;
        checked = 0;
        chars_seen = 0;
        ends_seen = 0;
    endfunction

    function void set_dot_unit(logic [11:0] value);
        dot_unit = value;
    endfunction

    function int pending();
        return text_q.size();
    endfunction

    function void push_text(int c, bit has, bit last);
        mktd_pkg::res_t r;
        r.character = c[6:0];
        r.has_char = has;
        r.message_end = last;
        text_q.push_back(r);
    endfunction

    // Close the letter in progress; 0 means nothing to emit
    function int finish_letter();
        int         cnt;
        logic [7:0] e;
        cnt = sym_count;
        sym_count = 0;
        if (cnt == 0) begin
            pattern = '0;
            return 0;
        end
        if (cnt > 7) begin
            pattern = '0;
            return mktd_pkg::CHAR_ILLEGAL;
        end
        e = code_rom[(1 << cnt) | (int'(pattern) & ((1 << cnt) - 1))];
        pattern = '0;
        if (e == mktd_pkg::ROM_EMPTY) return mktd_pkg::CHAR_ILLEGAL;
        if (e == mktd_pkg::ROM_PREFIX) return 0;
        return int'(e[6:0]);
    endfunction

    function void close_message();
        int c;
        c = finish_letter();
        in_message = 1'b0;
        if (c != 0) push_text(c, 1'b1, 1'b1);
        else push_text(0, 1'b0, 1'b1);
    endfunction

    // Predict the text caused by one accepted key request
    function void note_key(logic op, logic [15:0] dur);
        int   t;
        int   d;
        int   c;
        logic sym_bit;
        t = (dot_unit == 12'd0) ? 1 : int'(dot_unit);
        d = int'(dur);
        if (op == mktd_pkg::OP_MARK) begin
            if (d < 2 * t) begin
                sym_bit = 1'b0;
            end else if (d < 5 * t) begin
                sym_bit = 1'b1;
            end else begin
                close_message();
                return;
            end
            in_message = 1'b1;
            if (sym_count < 8) begin
                pattern = {pattern[5:0], sym_bit};
                sym_count++;
            end
            return;
        end
        if (!in_message) return;
        if (2 * d < 5 * t) return;
        if (d < 7 * t) begin
            c = finish_letter();
            if (c != 0) push_text(c, 1'b1, 1'b0);
        end else if (d < 21 * t) begin
            c = finish_letter();
            if (c != 0) push_text(c, 1'b1, 1'b0);
            push_text(mktd_pkg::CHAR_SPACE, 1'b1, 1'b0);
        end else begin
            close_message();
        end
    endfunction

    // Compare one accepted result with the oldest predicted one
    function void check_text(mktd_pkg::res_t got);
        mktd_pkg::res_t want;
        if (text_q.size() == 0) begin
            $error("unexpected result: character %0d, has_char %0d, message_end %0d",
                   got.character, got.has_char, got.message_end);
            errors++;
            return;
        end
        want = text_q.pop_front();
        checked++;
        if (got.has_char) chars_seen++;
        if (got.message_end) ends_seen++;
        if (got.character !== want.character) begin
            $error("character: expected %0d, actual %0d", want.character, got.character);
            errors++;
        end
        if (got.has_char !== want.has_char) begin
            $error("has_char: expected %0d, actual %0d", want.has_char, got.has_char);
            errors++;
        end
        if (got.message_end !== want.message_end) begin
            $error("message_end: expected %0d, actual %0d", want.message_end,
                   got.message_end);
            errors++;
        end
    endfunction
endclass

module tb_morse_key_timing_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mktd_pkg::*;

    localparam int KEYS_PER_PHASE = 200;
    localparam int NUM_PHASES     = 8;
    localparam int MAX_IDLE       = 5;
    localparam int QUIET_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DUR_MAX        = 65535;

    logic clk;
    logic rst_n;

    mktd_cfg_if    cfg_ch ();
    mktd_item_if   key_ch ();
    mktd_result_if text_ch ();

    morse_key_timing_decoder_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (key_ch),
        .result (text_ch)
    );

    morse_text_scoreboard sb = new();

    int keys_sent;
    int phases_run;
    int cycles;
    bit key_no_idle;
    bit text_no_idle;

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Pick a duration in [lo, hi], often right at one of the bounds
    function automatic int pick_span(int lo, int hi);
        int r;
        if (hi > DUR_MAX) hi = DUR_MAX;
        if (lo > hi) lo = hi;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return $urandom_range(hi, lo);
    endfunction

    function automatic int unit_now();
        return (sb.dot_unit == 12'd0) ? 1 : int'(sb.dot_unit);
    endfunction

    // Offer one key request after a random idle and hold it until accepted
    task automatic send_key(input logic op, input int dur);
        int idle;
        if ($urandom_range(0, 39) == 0) key_no_idle = !key_no_idle;
        idle = key_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (idle > 0) begin
            key_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        key_ch.valid <= 1'b1;
        key_ch.operation <= op;
        key_ch.duration_ms <= dur[DUR_W-1:0];
        @(posedge clk);
        while (!key_ch.ready) @(posedge clk);
        sb.note_key(op, dur[DUR_W-1:0]);
        keys_sent++;
    endtask

    // Drop the key request and wait until every predicted result has come out
    task automatic wait_quiet();
        key_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Write the dot unit register through its own request channel
    task automatic write_dot_unit(input logic [DOT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.dot_unit_ms <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        sb.set_dot_unit(value);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Directed keys at the reset dot unit of 200 ms
    task automatic send_directed();
        // gap before any mark is ignored; long mark before any mark ends the message
        send_key(OP_GAP, DUR_MAX);
        send_key(OP_MARK, DUR_MAX);
        // dot, dot, dash with intra gaps at both bounds, then a letter gap
        send_key(OP_MARK, 0);
        send_key(OP_GAP, 0);
        send_key(OP_MARK, 399);
        send_key(OP_GAP, 499);
        send_key(OP_MARK, 400);
        send_key(OP_GAP, 500);
        // longest dash, word gap at its lower bound, word gap with no letter
        send_key(OP_MARK, 999);
        send_key(OP_GAP, 1400);
        send_key(OP_GAP, 4199);
        // prefix-only code gives nothing
        send_key(OP_MARK, 0);
        send_key(OP_MARK, 0);
        send_key(OP_MARK, 400);
        send_key(OP_MARK, 400);
        send_key(OP_GAP, 500);
        // unknown code closed by a message-ending gap
        send_key(OP_MARK, 400);
        send_key(OP_MARK, 400);
        send_key(OP_MARK, 400);
        send_key(OP_MARK, 0);
        send_key(OP_MARK, 400);
        send_key(OP_GAP, 4200);
        // long mark outside a message at its lower bound
        send_key(OP_MARK, 1000);
    endtask

    // One message of random letters, mostly well formed, sometimes broken
    task automatic send_message();
        int         t;
        int         n_letters;
        int         len;
        int         r;
        logic [8:0] bits;
        t = unit_now();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                send_key(logic'($urandom_range(0, 1)), $urandom_range(0, DUR_MAX));
            end
        end
        n_letters = $urandom_range(1, 6);
        for (int l = 0; l < n_letters; l++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 6);
            bits = 9'($urandom);
            if (len == 7 && $urandom_range(0, 1) == 0) bits = 9'b0_0000_1001;
            for (int s = 0; s < len; s++) begin
                if (bits[len-1-s]) send_key(OP_MARK, pick_span(2 * t, 5 * t - 1));
                else send_key(OP_MARK, pick_span(0, 2 * t - 1));
                if (s < len - 1 && $urandom_range(0, 3) != 0) begin
                    send_key(OP_GAP, pick_span(0, (5 * t - 1) / 2));
                end
            end
            r = $urandom_range(0, 9);
            if (l < n_letters - 1) begin
                if (r >= 1 && r <= 6) send_key(OP_GAP, pick_span((5 * t + 1) / 2, 7 * t - 1));
                else if (r >= 7) send_key(OP_GAP, pick_span(7 * t, 21 * t - 1));
            end else if (r != 0) begin
                if (r == 1) send_key(OP_GAP, pick_span((5 * t + 1) / 2, 7 * t - 1));
                if (r < 6) send_key(OP_GAP, pick_span(21 * t, DUR_MAX));
                else send_key(OP_MARK, pick_span(5 * t, DUR_MAX));
            end
        end
    endtask

    // Result side: stall at random, check each accepted result
    initial begin
        mktd_pkg::res_t got;
        text_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 39) == 0) text_no_idle = !text_no_idle;
            if (!text_no_idle && $urandom_range(0, 1) == 1) begin
                text_ch.ready <= 1'b0;
                repeat ($urandom_range(1, MAX_IDLE)) @(posedge clk);
            end
            text_ch.ready <= 1'b1;
            @(posedge clk);
            while (!text_ch.valid) @(posedge clk);
            got.character = text_ch.character;
            got.has_char = text_ch.has_char;
            got.message_end = text_ch.message_end;
            sb.check_text(got);
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_morse_key_timing_decoder_top NOT OK");
        $finish;
    end

    // Main sequence: reset, directed keys, then phases over several dot units
    initial begin
        logic [DOT_W-1:0] unit_val;
        int               phase_start;
        keys_sent = 0;
        phases_run = 0;
        key_no_idle = 1'b0;
        text_no_idle = 1'b0;
        rst_n <= 1'b0;
        key_ch.valid <= 1'b0;
        key_ch.operation <= OP_MARK;
        key_ch.duration_ms <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.dot_unit_ms <= DOT_UNIT_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        wait_quiet();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: unit_val = 12'd1;
                1: unit_val = 12'd3000;
                2: unit_val = 12'd0;
                3: unit_val = DOT_UNIT_RESET;
                4: unit_val = DOT_W'($urandom_range(2, 16));
                default: unit_val = DOT_W'($urandom_range(1, 3000));
            endcase
            write_dot_unit(unit_val);
            phase_start = keys_sent;
            while (keys_sent - phase_start < KEYS_PER_PHASE) send_message();
            wait_quiet();
            phases_run++;
        end

        $display("Covered %0d key events over %0d dot-unit settings (0, 1, 3000 included)",
                 keys_sent, phases_run + 1);
        $display("Checked %0d results: %0d characters, %0d message ends",
                 sb.checked, sb.chars_seen, sb.ends_seen);
        if (sb.errors == 0) begin
            $display("tb_morse_key_timing_decoder_top OK");
        end else begin
            $display("tb_morse_key_timing_decoder_top NOT OK");
        end
        $finish;
    end
endmodule
